@@ design/kmds_pkg.sv @@
package kmds_pkg;

   localparam int ROW_W     = 2;
   localparam int ROW_SLOTS = 2 ** ROW_W;
   localparam int LEVEL_W   = 4;
   localparam int TIME_W    = 32;
   localparam int DEB_W     = 16;
   localparam int KEY_W     = 5;
   localparam int KSUM_W    = 8;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } key_event_type;

endpackage

@@ design/keypad_matrix_debounce_scanner_core.sv @@
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | row_index, column_levels, time_ms
// rsp     | out       | rsp_valid / rsp_ready | key_number, key_event, scan_any_pressed, last
// csr     | in        | csr_valid / csr_ready | debounce_ms (always ready)
//
// a request waits in the input register, then the whole row is
// debounced in one pass and its COLS responses go into the response buffer
// each request for a row below ROWS gives COLS responses (others are dropped),
// one per cycle while rsp_ready holds, so the output port sets the sustained rate
// synchronous active-high reset clears levels, scan flag and the handshake state
// a stalled rsp holds the buffer; the next row waits in the input register
module keypad_matrix_debounce_scanner_core #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kmds_pkg::ROW_W-1:0]      req_row_index,
   input  logic [kmds_pkg::LEVEL_W-1:0]    req_column_levels,
   input  logic [kmds_pkg::TIME_W-1:0]     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [kmds_pkg::KEY_W-1:0]      rsp_key_number,
   output logic [1:0]                      rsp_key_event,
   output logic                            rsp_scan_any_pressed,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kmds_pkg::DEB_W-1:0]      csr_debounce_ms
);

   localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

   logic [kmds_pkg::DEB_W-1:0] debounce_ff;

   logic                             s1_valid_ff;
   logic [kmds_pkg::ROW_W-1:0]       s1_row_ff;
   logic [kmds_pkg::LEVEL_W-1:0]     s1_levels_ff;
   logic [kmds_pkg::TIME_W-1:0]      s1_time_ff;

   logic [COLS-1:0]                  stable_ff    [kmds_pkg::ROW_SLOTS];
   logic [COLS-1:0]                  candidate_ff [kmds_pkg::ROW_SLOTS];
   logic [kmds_pkg::TIME_W-1:0]      change_ff    [kmds_pkg::ROW_SLOTS][COLS];
   logic                             any_acc_ff;

   logic                             buf_valid_ff;
   logic [CW-1:0]                    col_ff;
   logic [kmds_pkg::ROW_W-1:0]       buf_row_ff;
   kmds_pkg::key_event_type          evt_ff [COLS];
   logic [COLS-1:0]                  any_ff;

   logic                             row_ok;
   logic                             out_done;
   logic                             buf_free;
   logic                             s1_go;
   logic                             load_buf;

   logic [COLS-1:0]                  stable_in;
   logic [COLS-1:0]                  candidate_in;
   logic [kmds_pkg::TIME_W-1:0]      change_in [COLS];
   kmds_pkg::key_event_type          evt_in    [COLS];
   logic [COLS-1:0]                  any_in;

   logic [kmds_pkg::KSUM_W-1:0]      key_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kmds_pkg::DEBOUNCE_RESET;
      end else if (csr_valid) begin
         debounce_ff <= csr_debounce_ms;
      end
   end

   assign row_ok   = (32'(s1_row_ff) < 32'(ROWS));
   assign out_done = rsp_valid && rsp_ready && rsp_last;
   assign buf_free = !buf_valid_ff || out_done;
   assign s1_go    = s1_valid_ff && (buf_free || !row_ok);
   assign load_buf = s1_valid_ff && row_ok && buf_free;
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_row_ff    <= req_row_index;
         s1_levels_ff <= req_column_levels;
         s1_time_ff   <= req_time_ms;
      end
   end

   // one debounce pass over the selected row
   always_comb begin
      logic                        raw;
      logic                        fire;
      logic                        acc;
      logic [kmds_pkg::TIME_W-1:0] elapsed;
      acc = (s1_row_ff == '0) ? 1'b0 : any_acc_ff;
      for (int c = 0; c < COLS; c++) begin
         if (c < kmds_pkg::LEVEL_W) begin
            raw = !s1_levels_ff[2'(c)];
         end else begin
            raw = 1'b0;
         end
         candidate_in[c] = raw;
         if (raw != candidate_ff[s1_row_ff][c]) begin
            change_in[c] = s1_time_ff;
         end else begin
            change_in[c] = change_ff[s1_row_ff][c];
         end
         elapsed = s1_time_ff - change_in[c];
         fire = (elapsed > kmds_pkg::TIME_W'(debounce_ff))
                && (raw != stable_ff[s1_row_ff][c]);
         if (fire) begin
            stable_in[c] = raw;
            evt_in[c]    = raw ? kmds_pkg::EV_PRESS : kmds_pkg::EV_RELEASE;
         end else begin
            stable_in[c] = stable_ff[s1_row_ff][c];
            evt_in[c]    = kmds_pkg::EV_NONE;
         end
         acc = acc | stable_in[c];
         any_in[c] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < kmds_pkg::ROW_SLOTS; r++) begin
            stable_ff[r]    <= '0;
            candidate_ff[r] <= '0;
         end
         any_acc_ff <= 1'b0;
      end else if (load_buf) begin
         stable_ff[s1_row_ff]    <= stable_in;
         candidate_ff[s1_row_ff] <= candidate_in;
         any_acc_ff              <= any_in[COLS-1];
      end
   end

   // change time only matters once the candidate has moved, so no reset
   always_ff @(posedge clock) begin
      if (load_buf) begin
         for (int c = 0; c < COLS; c++) begin
            change_ff[s1_row_ff][c] <= change_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else if (load_buf) begin
         buf_valid_ff <= 1'b1;
         col_ff       <= '0;
      end else if (out_done) begin
         buf_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else if (rsp_valid && rsp_ready) begin
         col_ff <= col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_buf) begin
         buf_row_ff <= s1_row_ff;
         any_ff     <= any_in;
         for (int c = 0; c < COLS; c++) begin
            evt_ff[c] <= evt_in[c];
         end
      end
   end

   assign key_sum = kmds_pkg::KSUM_W'(buf_row_ff) * kmds_pkg::KSUM_W'(COLS)
                    + kmds_pkg::KSUM_W'(col_ff) + kmds_pkg::KSUM_W'(1);

   assign rsp_valid            = buf_valid_ff;
   assign rsp_key_number       = key_sum[kmds_pkg::KEY_W-1:0];
   assign rsp_key_event        = 2'(evt_ff[col_ff]);
   assign rsp_scan_any_pressed = any_ff[col_ff];
   assign rsp_last             = (col_ff == LAST_COL);

`ifndef SYNTHESIS
   a_load_starts_row: assert property (@(posedge clock) disable iff (reset)
      load_buf |=> (buf_valid_ff && col_ff == '0))
      else $error("row buffer not restarted after load");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      out_done |=> (col_ff == '0))
      else $error("column counter not rewound after last response");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (col_ff <= LAST_COL))
      else $error("column counter out of range");

   a_press_sets_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_event == 2'(kmds_pkg::EV_PRESS)) |-> rsp_scan_any_pressed)
      else $error("press reported without scan flag");
`endif

endmodule
